FILE: rtl/fic_pkg.sv
// shared types and constants for the float image converter
`default_nettype none
package fic_pkg;

  typedef enum logic [2:0] {
    REQ_DEC_SINGLE = 3'd0,
    REQ_ENC_SINGLE = 3'd1,
    REQ_DEC_DOUBLE = 3'd2,
    REQ_ENC_DOUBLE = 3'd3,
    REQ_DEC_EXT    = 3'd4,
    REQ_ENC_EXT    = 3'd5,
    REQ_RSVD6      = 3'd6,
    REQ_RSVD7      = 3'd7
  } req_e;

  localparam logic [63:0] F64_EXP_MASK  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] F64_FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [31:0] F32_INF       = 32'h7F80_0000;
  localparam logic [14:0] EXT_EXP_MAX   = 15'h7FFF;

  // stage 1 to stage 2 payload
  typedef struct packed {
    req_e        req;
    logic        sgn;
    logic [63:0] mant;     // normalized significand, msb set (or zero)
    logic [5:0]  lz;       // leading zero count of the raw significand
    logic        zero;     // raw significand zero
    logic [14:0] ex;       // ext exponent field
    logic [63:0] body;
    logic [63:0] val;
  } s1_t;

  // stage 2 to stage 3 payload
  typedef struct packed {
    req_e        req;
    logic        sgn;
    logic [63:0] q;        // shifted significand before rounding
    logic        rbit;
    logic        sticky;
    logic        normal;
    logic [12:0] be;       // biased double exponent (signed)
    logic        special;  // result fully decided in res
    logic [63:0] res_val;
    logic [15:0] res_top;
    logic [63:0] res_body;
  } s2_t;

endpackage
`default_nettype wire

FILE: rtl/float_image_converter.sv
// Float image converter: converts between binary64 bit patterns and the
// big-endian images of single, double and 80-bit extended precision. It is a
// three-register pipeline (normalize, align, round into the output register);
// one item enters each cycle while the output is not stalled, and a stall on
// the output holds the whole pipeline in place. Decodes
// map NaN to signed infinity; encodes give +0 for -0 and +infinity for NaN;
// single encodes truncate, extended decodes round to nearest even.
`default_nettype none
module float_image_converter (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [2:0]   req_type_i,
  input  wire logic [15:0]  image_top_i,
  input  wire logic [63:0]  image_body_i,
  input  wire logic [63:0]  value_bits_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [63:0]       value_bits_out_o,
  output logic [15:0]       image_top_out_o,
  output logic [63:0]       image_body_out_o
);
  import fic_pkg::*;

  logic adv;
  logic v1_q, v2_q, v3_q;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  logic [63:0] ov_d, ov_q, ob_d, ob_q;
  logic [15:0] ot_d, ot_q;

  assign adv        = !(v3_q && out_stall_i);
  assign in_stall_o = !adv;

  // stage 1: pick the significand to normalize and count leading zeros
  logic [63:0] raw;
  logic [5:0]  lzc;
  always_comb begin
    raw = 64'd0;
    case (req_e'(req_type_i))
      REQ_DEC_SINGLE: raw = {41'd0, image_body_i[22:0]};
      REQ_DEC_EXT:    raw = image_body_i;
      REQ_ENC_EXT:    raw = {12'd0, value_bits_i[51:0]};
      default:        raw = 64'd0;
    endcase
    lzc = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (raw[i]) lzc = 6'(63 - i);
    end
    s1_d.req  = req_e'(req_type_i);
    s1_d.sgn  = (req_e'(req_type_i) == REQ_DEC_EXT) ? image_top_i[15] :
                (req_e'(req_type_i) == REQ_DEC_SINGLE) ? image_body_i[31] :
                (req_e'(req_type_i) == REQ_DEC_DOUBLE) ? image_body_i[63] :
                value_bits_i[63];
    s1_d.lz   = lzc;
    s1_d.mant = raw << lzc;
    s1_d.zero = (raw == 64'd0);
    s1_d.ex   = image_top_i[14:0];
    s1_d.body = image_body_i;
    s1_d.val  = value_bits_i;
  end

  // stage 2: exponent work and alignment shift
  logic [10:0] e11;
  logic [7:0]  e8;
  logic [15:0] be;
  logic [6:0]  s;
  logic [63:0] m;
  logic [11:0] rsh;
  logic [52:0] m53;
  logic [14:0] ue;
  always_comb begin
    s2_d = '0;
    s2_d.req = s1_q.req;
    s2_d.sgn = s1_q.sgn;
    s2_d.special = 1'b1;
    e11 = s1_q.val[62:52];
    e8  = s1_q.body[30:23];
    m   = s1_q.mant;
    // ex - 16383 - 63 + p + 1023 with p = 63-lz
    be  = 16'(s1_q.ex) - 16'd15360 - 16'(s1_q.lz);
    s   = 7'd0;
    rsh = 12'd926 - 12'(e11);
    m53 = {1'b1, s1_q.val[51:0]};
    ue  = 15'd0;
    case (s1_q.req)
      REQ_DEC_SINGLE: begin
        if (s1_q.body[30:0] == 31'd0)
          s2_d.res_val = {s1_q.sgn, 63'd0};
        else if (e8 == 8'hFF)
          s2_d.res_val = {s1_q.sgn, 63'd0} | F64_EXP_MASK;
        else if (e8 == 8'd0)
          // msb at 63-lz; exponent p-149+1023 with p = 63-lz
          s2_d.res_val = {s1_q.sgn, 11'(11'd937 - 11'(s1_q.lz)), m[62:11]};
        else
          s2_d.res_val = {s1_q.sgn, 11'(11'(e8) + 11'd896),
                          s1_q.body[22:0], 29'd0};
      end
      REQ_ENC_SINGLE: begin
        if (s1_q.val[62:0] == 63'd0)
          s2_d.res_body = 64'd0;
        else if (e11 == 11'h7FF)
          s2_d.res_body = (s1_q.val[51:0] != 52'd0) ? {32'd0, F32_INF} :
                          {32'd0, F32_INF | {s1_q.sgn, 31'd0}};
        else if (e11 >= 11'd1151)
          s2_d.res_body = {32'd0, F32_INF | {s1_q.sgn, 31'd0}};
        else if (e11 >= 11'd897)
          s2_d.res_body = {32'd0, s1_q.sgn, 8'(e11 - 11'd896),
                           s1_q.val[51:29]};
        else if (e11 == 11'd0)
          s2_d.res_body = {32'd0, s1_q.sgn, 31'd0};
        else
          s2_d.res_body = {32'd0, s1_q.sgn, 31'd0} |
                          ((rsh >= 12'd64) ? 64'd0 : (64'(m53) >> rsh[5:0]));
      end
      REQ_DEC_DOUBLE: begin
        if (s1_q.body[62:52] == 11'h7FF)
          s2_d.res_val = {s1_q.body[63], 63'd0} | F64_EXP_MASK;
        else
          s2_d.res_val = s1_q.body;
      end
      REQ_ENC_DOUBLE: begin
        if (s1_q.val[62:0] == 63'd0)
          s2_d.res_body = 64'd0;
        else if (e11 == 11'h7FF && s1_q.val[51:0] != 52'd0)
          s2_d.res_body = F64_EXP_MASK;
        else
          s2_d.res_body = s1_q.val;
      end
      REQ_DEC_EXT: begin
        if (s1_q.ex == EXT_EXP_MAX)
          s2_d.res_val = {s1_q.sgn, 63'd0} | F64_EXP_MASK;
        else if (s1_q.zero)
          s2_d.res_val = {s1_q.sgn, 63'd0};
        else if (!be[15] && be >= 16'd2047)
          s2_d.res_val = {s1_q.sgn, 63'd0} | F64_EXP_MASK;
        else begin
          if (!be[15] && be != 16'd0) s = 7'd11;
          else if ($signed(be) <= -16'sd53) s = 7'd65;
          else s = 7'(16'd12 - be);
          if (s >= 7'd65)
            s2_d.res_val = {s1_q.sgn, 63'd0};
          else begin
            s2_d.special = 1'b0;
            s2_d.normal  = !be[15] && be != 16'd0;
            s2_d.be      = 13'(be);
            s2_d.q       = (s == 7'd64) ? 64'd0 : (m >> s[5:0]);
            s2_d.rbit    = m[6'(s - 7'd1)];
            s2_d.sticky  = (m & ((64'd1 << 6'(s - 7'd1)) - 64'd1)) != 64'd0;
          end
        end
      end
      REQ_ENC_EXT: begin
        if (s1_q.val[62:0] == 63'd0) begin
          s2_d.res_top = 16'd0;
        end else if (e11 == 11'h7FF) begin
          s2_d.res_top = (s1_q.val[51:0] != 52'd0) ? {1'b0, EXT_EXP_MAX} :
                         {s1_q.sgn, EXT_EXP_MAX};
        end else if (e11 == 11'd0) begin
          // p = 63-lz, ue = p-1074+16383
          ue = 15'd15372 - 15'(s1_q.lz);
          s2_d.res_top  = {s1_q.sgn, ue};
          s2_d.res_body = m;
        end else begin
          ue = 15'(e11) + 15'd15360;
          s2_d.res_top  = {s1_q.sgn, ue};
          s2_d.res_body = {m53, 11'd0};
        end
      end
      default: ;
    endcase
  end

  // stage 3: round to nearest even and assemble
  logic [63:0] qr;
  always_comb begin
    qr = s2_q.q + 64'(s2_q.rbit && (s2_q.sticky || s2_q.q[0]));
    ov_d = s2_q.res_val;
    ot_d = s2_q.res_top;
    ob_d = s2_q.res_body;
    if (!s2_q.special) begin
      if (s2_q.normal)
        ov_d = {s2_q.sgn, 63'd0} | (({51'd0, s2_q.be} - 64'd1) << 52) + qr;
      else
        ov_d = {s2_q.sgn, 63'd0} | qr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      ov_q <= ov_d;
      ot_q <= ot_d;
      ob_q <= ob_d;
    end
  end

  assign out_valid_o      = v3_q;
  assign value_bits_out_o = ov_q;
  assign image_top_out_o  = ot_q;
  assign image_body_out_o = ob_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(value_bits_out_o)))
    else $error("result changed while stalled");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted item lost in first stage");
`endif

endmodule
`default_nettype wire
